// ===== design/gcsd_pkg.sv =====
`timescale 1ns / 1ps
package gcsd_pkg;

   localparam int SAT_SLOTS_DEF = 64;

   localparam int SLOT_W     = 6;
   localparam int SYS_W      = 2;
   localparam int CODE_W     = 40;
   localparam int PHASE_W    = 41;
   localparam int OUT_W      = 41;
   localparam int FREQ_W     = 21;
   localparam int GFL_W      = 16;
   localparam int MWL_W      = 20;
   localparam int CNT_W      = 16;
   localparam int STATE_W    = 42;
   localparam int RAM_W      = 2 * STATE_W + CNT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   localparam int MUL_A_W   = 42;
   localparam int MUL_B_W   = 21;
   localparam int PROD_W    = MUL_A_W + MUL_B_W + 1;
   localparam int DIV_NUM_W = 84;
   localparam int DIV_DEN_W = 43;
   localparam int DIV_QUO_W = 43;

   localparam logic [FREQ_W-1:0] GPS_F1_RST = 21'd1575420;
   localparam logic [FREQ_W-1:0] GPS_F2_RST = 21'd1227600;
   localparam logic [FREQ_W-1:0] BDS_F1_RST = 21'd1561098;
   localparam logic [FREQ_W-1:0] BDS_F3_RST = 21'd1268520;
   localparam logic [GFL_W-1:0]  GF_LIMIT_RST = 16'd205;
   localparam logic [MWL_W-1:0]  MW_LIMIT_RST = 20'd12288;

   localparam logic signed [OUT_W-1:0] MAX41 = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] MIN41 = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GPS_F1   = 3'd0,
      CSR_GPS_F2   = 3'd1,
      CSR_BDS_F1   = 3'd2,
      CSR_BDS_F3   = 3'd3,
      CSR_GF_LIMIT = 3'd4,
      CSR_MW_LIMIT = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_SLIP        = 2'd1,
      STATUS_MISSING     = 2'd2,
      STATUS_UNSUPPORTED = 2'd3
   } status_type;

   typedef enum logic [SYS_W-1:0] {
      SYS_GPS = 2'd0,
      SYS_BDS = 2'd1
   } sys_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV1,
      ST_DIV1_WAIT,
      ST_CHECK,
      ST_SMUL,
      ST_SACC,
      ST_DIV2,
      ST_DIV2_WAIT,
      ST_FINISH
   } fsm_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } div_status_type;

endpackage

// ===== design/gcsd_req_if.sv =====
`timescale 1ns / 1ps
interface gcsd_req_if;
   logic                                valid;
   logic                                ready;
   logic [gcsd_pkg::SLOT_W-1:0]         slot;
   logic [gcsd_pkg::SYS_W-1:0]          constellation;
   logic [gcsd_pkg::CODE_W-1:0]         code1;
   logic [gcsd_pkg::CODE_W-1:0]         code2;
   logic signed [gcsd_pkg::PHASE_W-1:0] phase1;
   logic signed [gcsd_pkg::PHASE_W-1:0] phase2;

   modport source (output valid, slot, constellation, code1, code2, phase1, phase2,
                   input ready);
   modport sink (input valid, slot, constellation, code1, code2, phase1, phase2,
                 output ready);
endinterface

// ===== design/gcsd_rsp_if.sv =====
`timescale 1ns / 1ps
interface gcsd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic signed [gcsd_pkg::OUT_W-1:0] iono_free_range;
   logic signed [gcsd_pkg::OUT_W-1:0] mw_value;
   logic signed [gcsd_pkg::OUT_W-1:0] gf_value;
   logic [gcsd_pkg::CNT_W-1:0]        run_length;

   modport source (output valid, status, iono_free_range, mw_value, gf_value, run_length,
                   input ready);
   modport sink (input valid, status, iono_free_range, mw_value, gf_value, run_length,
                 output ready);
endinterface

// ===== design/gcsd_csr_if.sv =====
`timescale 1ns / 1ps
interface gcsd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gcsd_pkg::CSR_IDX_W-1:0]   index;
   logic [gcsd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/gcsd_ram.sv =====
`timescale 1ns / 1ps
module gcsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/gcsd_div.sv =====
`timescale 1ns / 1ps
module gcsd_div #(
   parameter int NUM_W = 84,
   parameter int DEN_W = 43,
   parameter int QUO_W = 43
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output logic [QUO_W-1:0]           quo,
   output gcsd_pkg::div_status_type   status
);
   localparam int HI_W  = NUM_W - QUO_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam int CW    = $clog2(QUO_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in, den_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff, ovf_ff;
   logic [DEN_W:0]   trial;
   logic             fits;
   logic [CMP_W-1:0] hi_ext, den_ext;

   assign hi_ext  = CMP_W'(num[NUM_W-1:QUO_W]);
   assign den_ext = CMP_W'(den);

   // restoring step: quotient bits shift in where numerator bits leave
   assign trial  = {rem_ff, quo_ff[QUO_W-1]};
   assign fits   = trial >= {1'b0, den_ff};
   assign rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(QUO_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DEN_W'(hi_ext);
         den_ff <= den;
         quo_ff <= num[QUO_W-1:0];
         ovf_ff <= hi_ext >= den_ext;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   assign quo         = quo_ff;
   assign status.done = done_ff;
   assign status.ovf  = ovf_ff;
endmodule

// ===== design/gnss_cycle_slip_detector_unit.sv =====
`timescale 1ns / 1ps
// channel  modport  handshake      word
// req_ch   sink     valid/ready    slot, constellation, code1/2, phase1/2
// rsp_ch   source   valid/ready    status, iono_free_range, mw_value, gf_value, run_length
// csr_ch   sink     valid, ready=1 index, data
//
// a tracked word runs 11 multiply steps on one shared 42x22 multiplier and two
// passes of a pair of bit-serial dividers, plus bookkeeping states; missing-data
// and unsupported words skip the arithmetic and go straight to the result register
// one word is worked at a time; req_ready is high only while idle
// rsp is registered, so the next word is taken while a result waits for rsp_ready
// synchronous reset clears the slot valid bits at once, no clearing pass
module gnss_cycle_slip_detector_unit #(
   parameter int SAT_SLOTS = gcsd_pkg::SAT_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gcsd_req_if.sink   req_ch,
   gcsd_rsp_if.source rsp_ch,
   gcsd_csr_if.sink   csr_ch
);
   import gcsd_pkg::*;

   localparam int SIDX_W = (SAT_SLOTS > 1) ? $clog2(SAT_SLOTS) : 1;

   // multiply step codes
   localparam logic [3:0] STEP_L1F1 = 4'd0;
   localparam logic [3:0] STEP_L2F2 = 4'd1;
   localparam logic [3:0] STEP_C1F1 = 4'd2;
   localparam logic [3:0] STEP_C2F2 = 4'd3;
   localparam logic [3:0] STEP_F1SQ = 4'd4;
   localparam logic [3:0] STEP_F2SQ = 4'd5;
   localparam logic [3:0] STEP_C1LO = 4'd6;
   localparam logic [3:0] STEP_C1HI = 4'd7;
   localparam logic [3:0] STEP_C2LO = 4'd8;
   localparam logic [3:0] STEP_C2HI = 4'd9;
   localparam logic [3:0] STEP_LAST = 4'd10;
   localparam logic [3:0] STEP_SMN  = 4'd11;
   localparam logic [3:0] STEP_NONE = 4'd15;

   function automatic logic signed [OUT_W-1:0] sat41(input logic signed [45:0] v);
      if (v > 46'(MAX41)) return MAX41;
      if (v < 46'(MIN41)) return MIN41;
      return v[OUT_W-1:0];
   endfunction

   // configuration registers
   logic [FREQ_W-1:0] gps_f1_ff, gps_f2_ff, bds_f1_ff, bds_f3_ff;
   logic [GFL_W-1:0]  gf_limit_ff;
   logic [MWL_W-1:0]  mw_limit_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gps_f1_ff   <= GPS_F1_RST;
         gps_f2_ff   <= GPS_F2_RST;
         bds_f1_ff   <= BDS_F1_RST;
         bds_f3_ff   <= BDS_F3_RST;
         gf_limit_ff <= GF_LIMIT_RST;
         mw_limit_ff <= MW_LIMIT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_GPS_F1:   gps_f1_ff   <= csr_ch.data;
            CSR_GPS_F2:   gps_f2_ff   <= csr_ch.data;
            CSR_BDS_F1:   bds_f1_ff   <= csr_ch.data;
            CSR_BDS_F3:   bds_f3_ff   <= csr_ch.data;
            CSR_GF_LIMIT: gf_limit_ff <= csr_ch.data[GFL_W-1:0];
            CSR_MW_LIMIT: mw_limit_ff <= csr_ch.data[MWL_W-1:0];
            default: ;
         endcase
      end
   end

   // slot folding table, built from constants
   logic [SIDX_W-1:0] slot_map [2**SLOT_W];
   for (genvar g = 0; g < 2**SLOT_W; g++) begin : g_slot_map
      assign slot_map[g] = SIDX_W'(g % SAT_SLOTS);
   end

   fsm_type state_ff, state_in;
   logic    accept, out_free;
   logic    special_in;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_ch.valid || rsp_ch.ready;
   assign special_in   = (req_ch.code1 == '0) || (req_ch.code2 == '0) ||
                         (req_ch.phase1 == '0) || (req_ch.phase2 == '0) ||
                         ((req_ch.constellation != SYS_GPS) &&
                          (req_ch.constellation != SYS_BDS));

   // word registers
   logic [SIDX_W-1:0]         sidx_ff;
   logic                      special_ff;
   status_type                kind_ff;
   logic [CODE_W-1:0]         c1_ff, c2_ff;
   logic signed [PHASE_W-1:0] l1_ff, l2_ff;
   logic [FREQ_W-1:0]         f1_ff, f2_ff;
   logic signed [STATE_W-1:0] gf_ff, sm_ff, lg_ff;
   logic [CNT_W-1:0]          n_ff;
   logic [3:0]                step_ff, prod_step_ff;

   // products and sums
   logic signed [PROD_W-1:0]    prod_ff, acc_a_ff, acc_b_ff, acc_s_ff;
   logic signed [DIV_NUM_W-1:0] acc_i_ff;
   logic [2*FREQ_W-1:0]         sq1_ff, sq2_ff;

   // results
   logic signed [OUT_W-1:0]   mw_ff, iono_ff;
   logic signed [STATE_W-1:0] sm_new_ff;
   logic                      clean_ff;
   logic                      x_neg_ff, x_zero_ff, y_neg_ff, y_zero_ff;

   // output register
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic signed [OUT_W-1:0] rsp_iono_ff, rsp_mw_ff, rsp_gf_ff;
   logic [CNT_W-1:0]        rsp_run_ff;

   // slot store, valid bits stand for the zero reset
   logic [SAT_SLOTS-1:0] vld_ff;
   logic [RAM_W-1:0]     ram_rd_data, ram_wr_data;
   logic                 ram_wr_en;

   gcsd_ram #(
      .WIDTH (RAM_W),
      .DEPTH (SAT_SLOTS),
      .AW    (SIDX_W)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (sidx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (slot_map[req_ch.slot]),
      .rd_data (ram_rd_data)
   );

   // shared multiplier, registered after
   logic [3:0]                 mul_sel;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]   mul_res;

   assign mul_sel = (state_ff == ST_MUL)  ? step_ff :
                    (state_ff == ST_SMUL) ? STEP_SMN : STEP_NONE;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (mul_sel)
         STEP_L1F1: begin mul_a = MUL_A_W'(l1_ff); mul_b = f1_ff; end
         STEP_L2F2: begin mul_a = MUL_A_W'(l2_ff); mul_b = f2_ff; end
         STEP_C1F1: begin mul_a = {2'b00, c1_ff}; mul_b = f1_ff; end
         STEP_C2F2: begin mul_a = {2'b00, c2_ff}; mul_b = f2_ff; end
         STEP_F1SQ: begin mul_a = MUL_A_W'({1'b0, f1_ff}); mul_b = f1_ff; end
         STEP_F2SQ: begin mul_a = MUL_A_W'({1'b0, f2_ff}); mul_b = f2_ff; end
         STEP_C1LO: begin mul_a = {2'b00, c1_ff}; mul_b = sq1_ff[FREQ_W-1:0]; end
         STEP_C1HI: begin mul_a = {2'b00, c1_ff}; mul_b = sq1_ff[2*FREQ_W-1:FREQ_W]; end
         STEP_C2LO: begin mul_a = {2'b00, c2_ff}; mul_b = sq2_ff[FREQ_W-1:0]; end
         STEP_C2HI: begin mul_a = {2'b00, c2_ff}; mul_b = sq2_ff[2*FREQ_W-1:FREQ_W]; end
         STEP_SMN:  begin mul_a = sm_ff; mul_b = MUL_B_W'(n_ff); end
         default: ;
      endcase
   end

   assign mul_res = mul_a * $signed({1'b0, mul_b});

   logic signed [DIV_NUM_W-1:0] prod_ext;
   assign prod_ext = DIV_NUM_W'(prod_ff);

   // divider operands: magnitudes, rounded by half the divisor
   logic signed [FREQ_W:0]    fdiff;
   logic [FREQ_W:0]           fsum;
   logic [FREQ_W-1:0]         fdiff_mag;
   logic signed [2*FREQ_W:0]  sqdiff;
   logic [2*FREQ_W:0]         sqdiff_mag;
   logic [PROD_W-1:0]         acc_a_mag, acc_s_mag;
   logic [DIV_NUM_W-1:0]      acc_i_mag;
   logic [CNT_W:0]            n_plus;
   logic [DIV_NUM_W-1:0]      x_num, y_num;
   logic [DIV_DEN_W-1:0]      x_den, y_den;
   logic                      div_start;
   logic [DIV_QUO_W-1:0]      x_quo, y_quo;
   div_status_type            x_st, y_st;

   assign fdiff      = $signed({1'b0, f1_ff}) - $signed({1'b0, f2_ff});
   assign fsum       = {1'b0, f1_ff} + {1'b0, f2_ff};
   assign fdiff_mag  = fdiff[FREQ_W] ? FREQ_W'(-fdiff) : fdiff[FREQ_W-1:0];
   assign sqdiff     = $signed({1'b0, sq1_ff}) - $signed({1'b0, sq2_ff});
   assign sqdiff_mag = sqdiff[2*FREQ_W] ? (2*FREQ_W+1)'(-sqdiff) : sqdiff;
   assign acc_a_mag  = acc_a_ff[PROD_W-1] ? PROD_W'(-acc_a_ff) : acc_a_ff;
   assign acc_s_mag  = acc_s_ff[PROD_W-1] ? PROD_W'(-acc_s_ff) : acc_s_ff;
   assign acc_i_mag  = acc_i_ff[DIV_NUM_W-1] ? DIV_NUM_W'(-acc_i_ff) : acc_i_ff;
   assign n_plus     = {1'b0, n_ff} + 1'b1;
   assign div_start  = (state_ff == ST_DIV1) || (state_ff == ST_DIV2);

   always_comb begin
      if (state_ff == ST_DIV1) begin
         x_num = DIV_NUM_W'(acc_a_mag) + DIV_NUM_W'(fdiff_mag >> 1);
         x_den = DIV_DEN_W'(fdiff_mag);
         y_num = DIV_NUM_W'(acc_b_ff) + DIV_NUM_W'(fsum >> 1);
         y_den = DIV_DEN_W'(fsum);
      end else begin
         x_num = DIV_NUM_W'(acc_s_mag) + DIV_NUM_W'(n_plus >> 1);
         x_den = DIV_DEN_W'(n_plus);
         y_num = acc_i_mag + DIV_NUM_W'(sqdiff_mag >> 1);
         y_den = DIV_DEN_W'(sqdiff_mag);
      end
   end

   gcsd_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .QUO_W (DIV_QUO_W)
   ) u_div_x (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (x_num),
      .den    (x_den),
      .quo    (x_quo),
      .status (x_st)
   );

   gcsd_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (DIV_DEN_W),
      .QUO_W (DIV_QUO_W)
   ) u_div_y (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (y_num),
      .den    (y_den),
      .quo    (y_quo),
      .status (y_st)
   );

   // mw from the two quotients; overflowed terms clamp to 2^43, which still
   // saturates the same way since the code term stays below 2^41
   logic [43:0]        a_mag, b_mag;
   logic signed [45:0] a_val, b_val, mw_wide;

   assign a_mag   = x_zero_ff ? '0 : (x_st.ovf ? {1'b1, 43'd0} : {1'b0, x_quo});
   assign b_mag   = y_zero_ff ? '0 : (y_st.ovf ? {1'b1, 43'd0} : {1'b0, y_quo});
   assign a_val   = x_neg_ff ? -$signed({2'b00, a_mag}) : $signed({2'b00, a_mag});
   assign b_val   = $signed({2'b00, b_mag});
   assign mw_wide = a_val - b_val;

   // jump tests
   logic signed [STATE_W:0] dgf_s, dmw_s;
   logic [STATE_W:0]        dgf_abs, dmw_abs;
   logic                    first_epoch, clean_in;

   assign dgf_s       = {gf_ff[STATE_W-1], gf_ff} - {lg_ff[STATE_W-1], lg_ff};
   assign dmw_s       = (STATE_W+1)'(mw_ff) - {sm_ff[STATE_W-1], sm_ff};
   assign dgf_abs     = dgf_s[STATE_W] ? (STATE_W+1)'(-dgf_s) : dgf_s;
   assign dmw_abs     = dmw_s[STATE_W] ? (STATE_W+1)'(-dmw_s) : dmw_s;
   assign first_epoch = (sm_ff == '0) && (lg_ff == '0);
   assign clean_in    = (first_epoch ? (gf_limit_ff != '0) : (dgf_abs < (STATE_W+1)'(gf_limit_ff)))
                     && (first_epoch ? (mw_limit_ff != '0) : (dmw_abs < (STATE_W+1)'(mw_limit_ff)));

   // second pass results
   logic                    i_sat;
   logic signed [OUT_W-1:0] iono_in;
   logic [CNT_W-1:0]        n_next;

   assign i_sat  = y_st.ovf || (y_quo[DIV_QUO_W-1:OUT_W-1] != '0);
   assign n_next = (n_ff == '1) ? n_ff : n_ff + 1'b1;

   always_comb begin
      if (y_zero_ff) begin
         iono_in = '0;
      end else if (y_neg_ff) begin
         iono_in = i_sat ? MIN41 : -$signed({1'b0, y_quo[OUT_W-2:0]});
      end else begin
         iono_in = i_sat ? MAX41 : $signed({1'b0, y_quo[OUT_W-2:0]});
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept) state_in = special_in ? ST_FINISH : ST_MUL;
         ST_MUL:       if (step_ff == STEP_LAST) state_in = ST_DIV1;
         ST_DIV1:      state_in = ST_DIV1_WAIT;
         ST_DIV1_WAIT: if (x_st.done) state_in = ST_CHECK;
         ST_CHECK:     state_in = ST_SMUL;
         ST_SMUL:      state_in = ST_SACC;
         ST_SACC:      state_in = ST_DIV2;
         ST_DIV2:      state_in = ST_DIV2_WAIT;
         ST_DIV2_WAIT: if (x_st.done) state_in = ST_FINISH;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff      <= mul_res;
      prod_step_ff <= mul_sel;

      if (accept) begin
         sidx_ff    <= slot_map[req_ch.slot];
         special_ff <= special_in;
         c1_ff      <= req_ch.code1;
         c2_ff      <= req_ch.code2;
         l1_ff      <= req_ch.phase1;
         l2_ff      <= req_ch.phase2;
         gf_ff      <= STATE_W'(req_ch.phase1) - STATE_W'(req_ch.phase2);
         step_ff    <= STEP_L1F1;
         // missing data wins over an unsupported system
         if ((req_ch.code1 == '0) || (req_ch.code2 == '0) ||
             (req_ch.phase1 == '0) || (req_ch.phase2 == '0)) begin
            kind_ff <= STATUS_MISSING;
         end else begin
            kind_ff <= STATUS_UNSUPPORTED;
         end
         if (req_ch.constellation == SYS_BDS) begin
            f1_ff <= bds_f1_ff;
            f2_ff <= bds_f3_ff;
         end else begin
            f1_ff <= gps_f1_ff;
            f2_ff <= gps_f2_ff;
         end
      end

      if (state_ff == ST_MUL) begin
         step_ff <= step_ff + 1'b1;
         // ram data lands in the first step
         if (step_ff == STEP_L1F1) begin
            if (vld_ff[sidx_ff]) begin
               sm_ff <= ram_rd_data[RAM_W-1 -: STATE_W];
               lg_ff <= ram_rd_data[CNT_W +: STATE_W];
               n_ff  <= ram_rd_data[CNT_W-1:0];
            end else begin
               sm_ff <= '0;
               lg_ff <= '0;
               n_ff  <= '0;
            end
         end
      end

      case (prod_step_ff)
         STEP_L1F1: acc_a_ff <= prod_ff;
         STEP_L2F2: acc_a_ff <= acc_a_ff - prod_ff;
         STEP_C1F1: acc_b_ff <= prod_ff;
         STEP_C2F2: acc_b_ff <= acc_b_ff + prod_ff;
         STEP_F1SQ: sq1_ff   <= prod_ff[2*FREQ_W-1:0];
         STEP_F2SQ: sq2_ff   <= prod_ff[2*FREQ_W-1:0];
         STEP_C1LO: acc_i_ff <= prod_ext;
         STEP_C1HI: acc_i_ff <= acc_i_ff + (prod_ext <<< FREQ_W);
         STEP_C2LO: acc_i_ff <= acc_i_ff - prod_ext;
         STEP_C2HI: acc_i_ff <= acc_i_ff - (prod_ext <<< FREQ_W);
         STEP_SMN:  acc_s_ff <= prod_ff + PROD_W'(mw_ff);
         default: ;
      endcase

      if (state_ff == ST_DIV1) begin
         x_neg_ff  <= acc_a_ff[PROD_W-1] ^ fdiff[FREQ_W];
         x_zero_ff <= (fdiff == '0);
         y_neg_ff  <= 1'b0;
         y_zero_ff <= (fsum == '0);
      end else if (state_ff == ST_DIV2) begin
         x_neg_ff  <= acc_s_ff[PROD_W-1];
         x_zero_ff <= 1'b0;
         y_neg_ff  <= acc_i_ff[DIV_NUM_W-1] ^ sqdiff[2*FREQ_W];
         y_zero_ff <= (sqdiff == '0);
      end

      if ((state_ff == ST_DIV1_WAIT) && x_st.done) begin
         mw_ff <= sat41(mw_wide);
      end
      if (state_ff == ST_CHECK) begin
         clean_ff <= clean_in;
      end
      if ((state_ff == ST_DIV2_WAIT) && x_st.done) begin
         sm_new_ff <= x_neg_ff ? -STATE_W'(x_quo) : STATE_W'(x_quo);
         iono_ff   <= iono_in;
      end
   end

   // result register and state write back
   assign ram_wr_en   = (state_ff == ST_FINISH) && out_free && !special_ff;
   assign ram_wr_data = clean_ff ? {sm_new_ff, gf_ff, n_next}
                                 : {STATE_W'(mw_ff), gf_ff, {CNT_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (!special_ff) begin
               vld_ff[sidx_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && out_free) begin
         if (special_ff) begin
            rsp_status_ff <= kind_ff;
            rsp_iono_ff   <= '0;
            rsp_mw_ff     <= '0;
            rsp_gf_ff     <= '0;
            rsp_run_ff    <= '0;
         end else begin
            rsp_status_ff <= clean_ff ? STATUS_OK : STATUS_SLIP;
            rsp_iono_ff   <= clean_ff ? iono_ff : '0;
            rsp_mw_ff     <= mw_ff;
            rsp_gf_ff     <= sat41(46'(gf_ff));
            rsp_run_ff    <= clean_ff ? n_next : '0;
         end
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.iono_free_range = rsp_iono_ff;
   assign rsp_ch.mw_value        = rsp_mw_ff;
   assign rsp_ch.gf_value        = rsp_gf_ff;
   assign rsp_ch.run_length      = rsp_run_ff;
endmodule
